// ===== hdl/mqtt_receive_packet_parser_top_macros.svh =====
// Assertion macros shared by the MQTT receive parser modules.
`ifndef MQTT_RECEIVE_PACKET_PARSER_TOP_MACROS_SVH
`define MQTT_RECEIVE_PACKET_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MQTTRX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MQTTRX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mqttrx_pkg.sv =====
// Types and constants for the MQTT 3.1.1 receive packet parser.
`default_nettype none
package mqttrx_pkg;

   localparam int unsigned LEN_W = 28;

   localparam logic [LEN_W-1:0] MAX_BODY_RESET = LEN_W'(1024 * 1024);

   localparam logic [3:0] TYPE_PUBLISH = 4'd3;
   localparam logic [3:0] TYPE_PINGREQ = 4'd12;

   localparam logic [2:0] KIND_HEADER    = 3'd0;
   localparam logic [2:0] KIND_LENGTH    = 3'd1;
   localparam logic [2:0] KIND_TOPIC_LEN = 3'd2;
   localparam logic [2:0] KIND_TOPIC     = 3'd3;
   localparam logic [2:0] KIND_PACKET_ID = 3'd4;
   localparam logic [2:0] KIND_PAYLOAD   = 3'd5;
   localparam logic [2:0] KIND_OTHER     = 3'd6;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
   localparam logic [1:0] ERR_MALFORMED = 2'd2;

   localparam logic [1:0] REPLY_NONE     = 2'd0;
   localparam logic [1:0] REPLY_PUBACK   = 2'd1;
   localparam logic [1:0] REPLY_PINGRESP = 2'd2;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic [2:0]  byte_kind;
      logic [3:0]  packet_type;
      logic [1:0]  qos_level;
      logic        retain_flag;
      logic [15:0] message_id;
      logic        packet_done;
      logic [1:0]  error_code;
      logic [1:0]  reply_kind;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/mqttrx_parser.sv =====
// Byte-level parse state and combinational classification of one stream byte.
`default_nettype none
`include "mqtt_receive_packet_parser_top_macros.svh"
module mqttrx_parser
   import mqttrx_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [7:0]       rx_byte,
   input  wire logic [LEN_W-1:0] max_body_length,
   output result_type            result
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_BODY
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       header_ff, header_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [1:0]       group_ff, group_in;
   logic [LEN_W-1:0] position_ff, position_in;
   logic [15:0]      topic_ff, topic_in;
   logic [15:0]      msg_id_ff, msg_id_in;

   logic [LEN_W-1:0] group_value;
   logic [LEN_W-1:0] length_sum;
   logic [16:0]      topic_end;
   logic [17:0]      id_end;
   logic [17:0]      need;
   logic             pub_cur;
   logic             ping_cur;
   logic [1:0]       qos_cur;
   logic             pub_out;

   always_comb begin
      case (group_ff)
         2'd0:    group_value = {21'b0, rx_byte[6:0]};
         2'd1:    group_value = {14'b0, rx_byte[6:0], 7'b0};
         2'd2:    group_value = {7'b0, rx_byte[6:0], 14'b0};
         default: group_value = {rx_byte[6:0], 21'b0};
      endcase
   end

   assign length_sum = length_ff + group_value;
   assign pub_cur    = (header_ff[7:4] == TYPE_PUBLISH);
   assign ping_cur   = (header_ff[7:4] == TYPE_PINGREQ);
   assign qos_cur    = header_ff[2:1];

   always_comb begin
      phase_in    = phase_ff;
      header_in   = header_ff;
      length_in   = length_ff;
      group_in    = group_ff;
      position_in = position_ff;
      topic_in    = topic_ff;
      msg_id_in   = msg_id_ff;
      topic_end   = '0;
      id_end      = '0;
      need        = '0;

      result             = '0;
      result.byte_value  = rx_byte;

      case (phase_ff)
         PH_LENGTH: begin
            result.byte_kind = KIND_LENGTH;
            length_in        = length_sum;
            if (rx_byte[7] && group_ff != 2'd3) begin
               group_in = group_ff + 2'd1;
            end else if (length_sum > max_body_length) begin
               result.packet_done = 1'b1;
               result.error_code  = ERR_TOO_LARGE;
               phase_in           = PH_HEADER;
            end else if (length_sum == '0) begin
               result.packet_done = 1'b1;
               if (pub_cur) begin
                  result.error_code = ERR_MALFORMED;
               end else if (ping_cur) begin
                  result.reply_kind = REPLY_PINGRESP;
               end
               phase_in = PH_HEADER;
            end else begin
               position_in = '0;
               topic_in    = '0;
               msg_id_in   = '0;
               phase_in    = PH_BODY;
            end
         end
         PH_BODY: begin
            if (pub_cur) begin
               // The two leading body bytes carry the topic length, high byte first.
               if (position_ff < LEN_W'(2)) begin
                  result.byte_kind = KIND_TOPIC_LEN;
                  topic_in         = {topic_ff[7:0], rx_byte};
               end
               topic_end = 17'd2 + {1'b0, topic_in};
               id_end    = {1'b0, topic_end} + 18'd2;
               if (position_ff >= LEN_W'(2)) begin
                  if (position_ff < {11'b0, topic_end}) begin
                     result.byte_kind = KIND_TOPIC;
                  end else if (qos_cur != 2'd0 && position_ff < {10'b0, id_end}) begin
                     result.byte_kind = KIND_PACKET_ID;
                     msg_id_in        = {msg_id_ff[7:0], rx_byte};
                  end else begin
                     result.byte_kind = KIND_PAYLOAD;
                  end
               end
               result.message_id = msg_id_in;
            end else begin
               result.byte_kind = KIND_OTHER;
            end
            if ({1'b0, position_ff} + 29'd1 >= {1'b0, length_ff}) begin
               result.packet_done = 1'b1;
               need = {1'b0, topic_end} + ((qos_cur != 2'd0) ? 18'd2 : 18'd0);
               if (pub_cur) begin
                  if (length_ff < LEN_W'(2) || {10'b0, need} > length_ff) begin
                     result.error_code = ERR_MALFORMED;
                  end else if (qos_cur == 2'd1 && msg_id_in != 16'd0) begin
                     result.reply_kind = REPLY_PUBACK;
                  end
               end else if (ping_cur) begin
                  result.reply_kind = REPLY_PINGRESP;
               end
               phase_in = PH_HEADER;
            end else begin
               position_in = position_ff + LEN_W'(1);
            end
         end
         default: begin
            result.byte_kind = KIND_HEADER;
            header_in        = rx_byte;
            length_in        = '0;
            group_in         = '0;
            phase_in         = PH_LENGTH;
         end
      endcase

      // Header fields always come from the header byte as it stands after this item.
      pub_out            = (header_in[7:4] == TYPE_PUBLISH);
      result.packet_type = header_in[7:4];
      result.qos_level   = pub_out ? header_in[2:1] : 2'd0;
      result.retain_flag = pub_out ? header_in[0] : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         header_ff   <= '0;
         length_ff   <= '0;
         group_ff    <= '0;
         position_ff <= '0;
         topic_ff    <= '0;
         msg_id_ff   <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         header_ff   <= header_in;
         length_ff   <= length_in;
         group_ff    <= group_in;
         position_ff <= position_in;
         topic_ff    <= topic_in;
         msg_id_ff   <= msg_id_in;
      end
   end

   `MQTTRX_ASSERT_NOW(a_err_on_done, result.error_code != ERR_NONE, result.packet_done,
      "error reported on a byte that does not end a packet")
   `MQTTRX_ASSERT_NOW(a_reply_on_done, result.reply_kind != REPLY_NONE, result.packet_done,
      "reply requested on a byte that does not end a packet")
   `MQTTRX_ASSERT_NEXT(a_done_to_header, advance && result.packet_done, phase_ff == PH_HEADER,
      "parser did not return to the header phase after a packet end")
   `MQTTRX_ASSERT_NEXT(a_header_to_length, advance && phase_ff == PH_HEADER,
      phase_ff == PH_LENGTH, "header byte not followed by the length phase")

endmodule
`default_nettype wire

// ===== hdl/mqtt_receive_packet_parser_top.sv =====
// MQTT 3.1.1 receive parser: one stream byte in, one classified byte out.
//
// Input channel req_*: one received stream byte per item in req_tdata.
// Result channel rsp_*: one item per input byte, carrying the byte, its kind
// (rsp_tuser), the header fields, the packet id, error and reply request;
// rsp_tlast marks the last byte of a packet.
// Configuration channel csr_*: writes max_body_length; always ready. It must be
// written only while no item is in flight; the block itself does not enforce this.
// An accepted byte waits in the input register and is classified into the
// result register, from which its result is offered. Throughput: one item
// per cycle while the receiver does not stall, limited by the single parse
// state update per byte.
// Reset clears the parse state to wait for a header byte, empties both
// registers and restores max_body_length to 1048576.
// When the receiver stalls, the result register holds and the input register
// fills; req_tready then drops until the result is taken.
`default_nettype none
`include "mqtt_receive_packet_parser_top_macros.svh"
module mqtt_receive_packet_parser_top
   import mqttrx_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [7:0]       req_tdata,   // [7:0] rx_byte
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [39:0]      rsp_tdata,   // [7:0] byte_value, [11:8] packet_type,
                                              // [13:12] qos_level, [14] retain_flag,
                                              // [30:15] message_id, [32:31] error_code,
                                              // [34:33] reply_kind, [39:35] zero
   output      logic [2:0]       rsp_tuser,   // [2:0] byte_kind
   output      logic             rsp_tlast,   // packet_done
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [LEN_W-1:0] csr_data     // [27:0] max_body_length
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;
   logic [LEN_W-1:0] max_len_ff;
   logic             out_free;
   logic             advance;
   result_type       parsed;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   mqttrx_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .rx_byte         (in_byte_ff),
      .max_body_length (max_len_ff),
      .result          (parsed)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = parsed;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_len_ff   <= MAX_BODY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_data;
         end
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.byte_kind;
   assign rsp_tlast  = out_ff.packet_done;
   assign rsp_tdata  = {5'b0, out_ff.reply_kind, out_ff.error_code, out_ff.message_id,
                        out_ff.retain_flag, out_ff.qos_level, out_ff.packet_type,
                        out_ff.byte_value};

   `MQTTRX_ASSERT_NEXT(a_adv_fills_out, advance, out_valid_ff,
      "parsed item did not reach the result register")
   `MQTTRX_ASSERT_NEXT(a_held_input_kept, in_valid_ff && !out_free,
      in_valid_ff && $stable(in_byte_ff), "pending input item lost during a stall")
   `MQTTRX_ASSERT_NOW(a_done_kind, out_valid_ff && out_ff.packet_done,
      out_ff.byte_kind != KIND_HEADER, "a header byte was marked as a packet end")

endmodule
`default_nettype wire

// ===== sim/mqtt_receive_packet_parser_checker.sv =====
// Checker for the MQTT receive parser: predicts each result item and compares it with the block.
module mqtt_receive_packet_parser_checker
   import mqttrx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [39:0]      rsp_tdata,
   input  logic [2:0]       rsp_tuser,
   input  logic             rsp_tlast,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [LEN_W-1:0] csr_data,
   output int unsigned      fail_count,
   output int unsigned      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {AWAIT_HEADER, IN_LENGTH, IN_BODY} parse_phase_type;

   parse_phase_type  phase;
   logic [7:0]       hdr;
   logic [LEN_W-1:0] body_len;
   logic [1:0]       groups_seen;
   logic [LEN_W-1:0] body_pos;
   logic [15:0]      topic_len;
   logic [15:0]      held_id;
   logic [LEN_W-1:0] max_len;

   result_type       classified_bytes[$];
   result_type       want;

   task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                  input logic [31:0] got_val);
      $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, exp_val, got_val);
      fail_count = fail_count + 1;
   endtask

   task automatic check_field(input string what, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (got_val !== exp_val)
         report_mismatch({"mismatch on ", what}, exp_val, got_val);
   endtask

   // Advances the parse state by one stream byte and returns the classified result.
   task automatic parse_byte(input logic [7:0] b, output result_type r);
      logic [31:0] pos;
      logic [31:0] topic_end;
      logic [31:0] need;
      logic [31:0] sum;
      logic        publish;
      logic [1:0]  qos;
      r = '0;
      r.byte_value = b;
      r.byte_kind = KIND_HEADER;
      publish = (hdr[7:4] == TYPE_PUBLISH);
      qos = hdr[2:1];
      case (phase)
         IN_LENGTH: begin
            r.byte_kind = KIND_LENGTH;
            sum = {4'd0, body_len} + ({25'd0, b[6:0]} << (7 * groups_seen));
            body_len = sum[LEN_W-1:0];
            // A fourth group ends the length field even with its continuation bit set.
            if (b[7] && groups_seen < 2'd3) begin
               groups_seen = groups_seen + 2'd1;
            end else if (body_len > max_len) begin
               r.packet_done = 1'b1;
               r.error_code = ERR_TOO_LARGE;
               phase = AWAIT_HEADER;
            end else if (body_len == '0) begin
               r.packet_done = 1'b1;
               if (publish)
                  r.error_code = ERR_MALFORMED;
               else if (hdr[7:4] == TYPE_PINGREQ)
                  r.reply_kind = REPLY_PINGRESP;
               phase = AWAIT_HEADER;
            end else begin
               body_pos = '0;
               topic_len = '0;
               held_id = '0;
               phase = IN_BODY;
            end
         end
         IN_BODY: begin
            pos = {4'd0, body_pos};
            if (publish) begin
               if (pos < 32'd2) begin
                  r.byte_kind = KIND_TOPIC_LEN;
                  topic_len = {topic_len[7:0], b};
               end
               topic_end = 32'd2 + topic_len;
               if (pos >= 32'd2) begin
                  if (pos < topic_end) begin
                     r.byte_kind = KIND_TOPIC;
                  end else if (qos != 2'd0 && pos < topic_end + 32'd2) begin
                     r.byte_kind = KIND_PACKET_ID;
                     held_id = {held_id[7:0], b};
                  end else begin
                     r.byte_kind = KIND_PAYLOAD;
                  end
               end
               r.message_id = held_id;
            end else begin
               r.byte_kind = KIND_OTHER;
            end
            if (pos + 32'd1 >= {4'd0, body_len}) begin
               r.packet_done = 1'b1;
               if (publish) begin
                  need = 32'd2 + topic_len + ((qos != 2'd0) ? 32'd2 : 32'd0);
                  if (body_len < 2 || need > {4'd0, body_len})
                     r.error_code = ERR_MALFORMED;
                  else if (qos == 2'd1 && held_id != 16'd0)
                     r.reply_kind = REPLY_PUBACK;
               end else if (hdr[7:4] == TYPE_PINGREQ) begin
                  r.reply_kind = REPLY_PINGRESP;
               end
               phase = AWAIT_HEADER;
            end else begin
               body_pos = body_pos + 28'd1;
            end
         end
         default: begin
            hdr = b;
            body_len = '0;
            groups_seen = '0;
            phase = IN_LENGTH;
         end
      endcase
      r.packet_type = hdr[7:4];
      if (hdr[7:4] == TYPE_PUBLISH) begin
         r.qos_level = hdr[2:1];
         r.retain_flag = hdr[0];
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = AWAIT_HEADER;
         hdr = '0;
         body_len = '0;
         groups_seen = '0;
         body_pos = '0;
         topic_len = '0;
         held_id = '0;
         max_len = MAX_BODY_RESET;
         classified_bytes.delete();
      end else begin
         // Results are taken before new bytes are predicted: a result never
         // leaves in the same cycle as its own byte enters.
         if (rsp_tvalid && rsp_tready) begin
            if (classified_bytes.size() == 0) begin
               report_mismatch("result item with nothing expected, byte_value", 32'd0,
                               {24'd0, rsp_tdata[7:0]});
            end else begin
               want = classified_bytes.pop_front();
               check_field("byte_value", 32'(want.byte_value), 32'(rsp_tdata[7:0]));
               check_field("byte_kind", 32'(want.byte_kind), 32'(rsp_tuser));
               check_field("packet_type", 32'(want.packet_type), 32'(rsp_tdata[11:8]));
               check_field("qos_level", 32'(want.qos_level), 32'(rsp_tdata[13:12]));
               check_field("retain_flag", 32'(want.retain_flag), 32'(rsp_tdata[14]));
               check_field("message_id", 32'(want.message_id), 32'(rsp_tdata[30:15]));
               check_field("packet_done", 32'(want.packet_done), 32'(rsp_tlast));
               check_field("error_code", 32'(want.error_code), 32'(rsp_tdata[32:31]));
               check_field("reply_kind", 32'(want.reply_kind), 32'(rsp_tdata[34:33]));
            end
         end
         if (csr_valid && csr_ready)
            max_len = csr_data;
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, want);
            classified_bytes = {classified_bytes, want};
         end
      end
      outstanding <= classified_bytes.size();
   end

endmodule

// ===== sim/mqtt_receive_packet_parser_top_tb.sv =====
// Testbench top for the MQTT receive parser: clock, reset, byte stimulus and verdict.
module mqtt_receive_packet_parser_top_tb
   import mqttrx_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [LEN_W-1:0] MAX_LEN_ALL_ONES = 28'hFFFFFFF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [39:0]      rsp_tdata;
   logic [2:0]       rsp_tuser;
   logic             rsp_tlast;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_data = '0;

   int unsigned      fail_count;
   int unsigned      outstanding;

   logic [7:0]       frame_bytes[$];
   logic [LEN_W-1:0] max_setting = MAX_BODY_RESET;
   bit               steady = 1'b0;
   int unsigned      hold_requests = 0;
   int unsigned      holds_done = 0;

   // PINGREQ empty, PUBLISH empty, QoS 1 PUBLISH with id 0x1234, a length whose
   // fourth group keeps its continuation bit, an oversize PUBLISH, PINGREQ with a body.
   logic [7:0] directed_bytes [26] = '{
      8'hC0, 8'h00,
      8'h30, 8'h00,
      8'h32, 8'h06, 8'h00, 8'h01, 8'h61, 8'h12, 8'h34, 8'hFF,
      8'h20, 8'h81, 8'h80, 8'h80, 8'h80, 8'h55,
      8'h30, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
      8'hC0, 8'h01, 8'hAA
   };

   mqtt_receive_packet_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mqtt_receive_packet_parser_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 70)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   task automatic push_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits until every result is back, then writes the length limit.
   task automatic write_max_length(input logic [LEN_W-1:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      max_setting = value;
   endtask

   // Appends a remaining length, sometimes padded with empty continuation groups.
   task automatic append_length(input int unsigned len);
      logic [7:0]  groups[$];
      int unsigned rest;
      int unsigned target;
      logic [7:0]  g;
      rest = len;
      do begin
         g = {1'b0, rest[6:0]};
         rest = rest >> 7;
         if (rest != 0)
            g[7] = 1'b1;
         groups = {groups, g};
      end while (rest != 0);
      if (groups.size() < 4 && $urandom_range(0, 7) == 0) begin
         target = $urandom_range(groups.size() + 1, 4);
         groups[groups.size() - 1][7] = 1'b1;
         while (groups.size() < target - 1)
            groups = {groups, 8'h80};
         groups = {groups, ((target == 4 && $urandom_range(0, 1) == 1) ? 8'h80 : 8'h00)};
      end
      foreach (groups[i])
         frame_bytes = {frame_bytes, groups[i]};
   endtask

   // Builds one packet into frame_bytes: mostly well-formed, some truncated,
   // oversize or raw noise where the current limit lets the parser recover.
   task automatic build_frame();
      int unsigned pick;
      int unsigned tl;
      int unsigned pl;
      int unsigned n;
      logic [31:0] big_len;
      logic [1:0]  qos;
      logic [15:0] id;
      logic [7:0]  hdr;
      logic [7:0]  body[$];
      frame_bytes.delete();
      steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8 && max_setting <= 64) begin
         n = $urandom_range(1, 6);
         repeat (n) frame_bytes = {frame_bytes, 8'($urandom)};
      end else if (pick < 14 && max_setting != MAX_LEN_ALL_ONES) begin
         frame_bytes = {frame_bytes, 8'($urandom)};
         big_len = {4'd0, max_setting} + $urandom_range(1, 100);
         if (big_len > {4'd0, MAX_LEN_ALL_ONES})
            big_len = {4'd0, MAX_LEN_ALL_ONES};
         append_length(big_len);
      end else begin
         if (pick < 66) begin
            qos = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            tl = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
            pl = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 150)
                                               : $urandom_range(0, 6);
            id = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            hdr = {TYPE_PUBLISH, 1'($urandom), qos, 1'($urandom)};
            body = {body, tl[15:8]};
            body = {body, tl[7:0]};
            repeat (tl) body = {body, 8'($urandom)};
            if (qos != 2'd0) begin
               body = {body, id[15:8]};
               body = {body, id[7:0]};
            end
            repeat (pl) body = {body, 8'($urandom)};
            // Cut the body short, which can leave the length too small to cover its fields.
            if (pick >= 56) begin
               n = $urandom_range(0, body.size() - 1);
               while (body.size() > n)
                  void'(body.pop_back());
            end
         end else if (pick < 80) begin
            hdr = {TYPE_PINGREQ, 4'($urandom)};
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n) body = {body, 8'($urandom)};
         end else begin
            hdr = 8'($urandom);
            n = $urandom_range(0, 4);
            repeat (n) body = {body, 8'($urandom)};
         end
         frame_bytes = {frame_bytes, hdr};
         append_length(body.size());
         foreach (body[i])
            frame_bytes = {frame_bytes, body[i]};
      end
   endtask

   // Result side: random stalls, mostly short, and one long hold-off on request.
   initial begin
      int unsigned r;
      @(posedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            rsp_tready <= 1'b0;
            repeat (120) @(posedge clock);
            holds_done = holds_done + 1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_tready <= 1'b1;
               repeat ((r < 5) ? 80 : $urandom_range(1, 12)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30))
                  @(posedge clock);
            end
         end
      end
   end

   initial begin
      logic [LEN_W-1:0] limits [5];
      int unsigned      budget;
      int unsigned      sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_bytes[i])
         push_byte(directed_bytes[i]);
      limits = '{MAX_LEN_ALL_ONES, 28'd0, 28'd24, MAX_BODY_RESET,
                 28'($urandom_range(200, 5000))};
      foreach (limits[k]) begin
         write_max_length(limits[k]);
         if (k == 0)
            hold_requests = hold_requests + 1;
         budget = (limits[k] == 0) ? 30 : 90;
         sent = 0;
         while (sent < budget) begin
            build_frame();
            sent = sent + frame_bytes.size();
            foreach (frame_bytes[j])
               push_byte(frame_bytes[j]);
         end
      end
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("** mqtt_receive_packet_parser_top: PASSED **");
      else
         $display("** mqtt_receive_packet_parser_top: FAILED **");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", outstanding);
      $display("** mqtt_receive_packet_parser_top: FAILED **");
      $finish;
   end

endmodule
